FILE: rtl/core/tih_pkg.sv
// tih_pkg: types, constants and the halfsiphash round for the tcp isn keyed hash
// used by tih_cell and tcp_isn_keyed_hash; no dependencies
`default_nettype none

package tih_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_ROUNDS = 7;
  localparam int MSG_WORDS  = 4;
  localparam int MSG_W      = MSG_WORDS * WORD_W;

  localparam logic [WORD_W-1:0] SIP_C0   = 32'h6c796765;
  localparam logic [WORD_W-1:0] SIP_C1   = 32'h74656462;
  localparam logic [WORD_W-1:0] FIN_KICK = 32'h000000ff;
  localparam logic [WORD_W-1:0] LEN_WORD = 32'h0c000000;

  // kick flag sits at the first finalization round
  localparam logic [NUM_ROUNDS-1:0] KICK_INIT = 7'b0010000;

  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0]     v0;
    logic [WORD_W-1:0]     v1;
    logic [WORD_W-1:0]     v2;
    logic [WORD_W-1:0]     v3;
    logic [MSG_W-1:0]      msg;
    logic [NUM_ROUNDS-1:0] kick;
    logic [WORD_W-1:0]     base;
  } tih_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
  } tih_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic tih_state_t sip_round(input tih_state_t s);
    tih_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1; r.v1 = rotl(r.v1, 5);  r.v1 = r.v1 ^ r.v0; r.v0 = rotl(r.v0, 16);
    r.v2 = r.v2 + r.v3; r.v3 = rotl(r.v3, 8);  r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3; r.v3 = rotl(r.v3, 7);  r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1; r.v1 = rotl(r.v1, 13); r.v1 = r.v1 ^ r.v2; r.v2 = rotl(r.v2, 16);
    sip_round = r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tih_cell.sv
// tih_cell: one pipeline cell, absorbs its message word and runs one sip round
// depends on tih_pkg
`default_nettype none

module tih_cell
  import tih_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire tih_word_t up_word,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output tih_word_t      dn_word
);

  logic       valid_r;
  tih_word_t  word_r;
  tih_word_t  word_nxt;
  tih_state_t pre;
  tih_state_t post;
  logic [WORD_W-1:0] m;

  always_comb begin
    m      = up_word.msg[WORD_W-1:0];
    pre.v0 = up_word.v0;
    pre.v1 = up_word.v1;
    pre.v2 = up_word.v2 ^ (up_word.kick[0] ? FIN_KICK : '0);
    pre.v3 = up_word.v3 ^ m;
    post   = sip_round(pre);
    word_nxt.v0   = post.v0 ^ m;
    word_nxt.v1   = post.v1;
    word_nxt.v2   = post.v2;
    word_nxt.v3   = post.v3;
    word_nxt.msg  = {{WORD_W{1'b0}}, up_word.msg[MSG_W-1:WORD_W]};
    word_nxt.kick = {1'b0, up_word.kick[NUM_ROUNDS-1:1]};
    word_nxt.base = up_word.base;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcp_isn_keyed_hash.sv
// tcp_isn_keyed_hash: top level, key registers, chain of round cells, output register
// depends on tih_pkg and tih_cell
`default_nettype none

// Keyed TCP initial sequence number: base_sequence plus HalfSipHash-1-3 of the
// connection 4-tuple under a 64-bit key written through the cfg port. The hash
// runs as a chain of seven round cells (three message words, the length word,
// three finalization rounds), one round per cell, followed by an output register
// that adds the base. A new word is taken every cycle while the output side does
// not stall; each result passes through the seven cell registers and then the
// output register. Write the key only while the block is empty.

module tcp_isn_keyed_hash
  import tih_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_local_address,
  input  wire logic [15:0] in_local_tcp_port,
  input  wire logic [31:0] in_remote_address,
  input  wire logic [15:0] in_remote_tcp_port,
  input  wire logic [31:0] in_base_sequence,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_initial_sequence
);

  logic [WORD_W-1:0] key_low_r;
  logic [WORD_W-1:0] key_high_r;
  logic [WORD_W-1:0] m0, m1, m2;
  tih_word_t         head;

  tih_word_t         chain_word  [NUM_ROUNDS+1];
  logic              chain_valid [NUM_ROUNDS+1];
  logic              chain_ready [NUM_ROUNDS+1];

  logic              out_valid_r;
  logic [WORD_W-1:0] out_isn_r;
  logic [WORD_W-1:0] out_isn_nxt;
  logic              tail_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_write_data;
        CFG_KEY_HIGH: key_high_r <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // message octets in network order, packed lsb first
  always_comb begin
    m0 = {in_local_address[7:0], in_local_address[15:8],
          in_local_address[23:16], in_local_address[31:24]};
    m1 = {in_remote_address[23:16], in_remote_address[31:24],
          in_local_tcp_port[7:0], in_local_tcp_port[15:8]};
    m2 = {in_remote_tcp_port[7:0], in_remote_tcp_port[15:8],
          in_remote_address[7:0], in_remote_address[15:8]};
    head.v0   = key_low_r;
    head.v1   = key_high_r;
    head.v2   = key_low_r ^ SIP_C0;
    head.v3   = key_high_r ^ SIP_C1;
    head.msg  = {LEN_WORD, m2, m1, m0};
    head.kick = KICK_INIT;
    head.base = in_base_sequence;
  end

  assign chain_word[0]  = head;
  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
    tih_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_word  (chain_word[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_word  (chain_word[i+1])
    );
  end

  assign tail_ready              = !out_valid_r || out_ready;
  assign chain_ready[NUM_ROUNDS] = tail_ready;
  assign out_isn_nxt = chain_word[NUM_ROUNDS].base
                       + (chain_word[NUM_ROUNDS].v1 ^ chain_word[NUM_ROUNDS].v3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_ready) begin
      out_valid_r <= chain_valid[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready && chain_valid[NUM_ROUNDS]) begin
      out_isn_r <= out_isn_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_initial_sequence = out_isn_r;

  // a full pipe always has a result on offer
  a_stall_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while no result pending");

  // free output drains the whole chain back to the input
  a_ready_ripples: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("output ready did not reach the input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

`default_nettype wire
